// ===== hdl/sparse_matrix_vector_multiply_defines.svh =====
// Assertion macros shared by the checker of the sparse matrix vector block.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smv assertion failed");

// Next-cycle implication, checked outside reset.
`define SMV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smv assertion failed");

`endif

// ===== hdl/smv_pkg.sv =====
// Types, constants and codes of the sparse matrix vector block.
package smv_pkg;

  localparam int DIM     = 64;
  localparam int NNZ_MAX = 1024;
  localparam int IDX_W   = $clog2(NNZ_MAX);
  localparam int CNT_W   = $clog2(NNZ_MAX + 1);
  localparam int VIDX_W  = $clog2(DIM);
  localparam int N_W     = $clog2(DIM + 1);
  localparam int ROW_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 48;

  // Request codes.
  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] REQ_LOAD_VEC   = 2'd1;
  localparam logic [1:0] REQ_RUN        = 2'd2;
  localparam logic [1:0] REQ_CLEAR      = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SYMMETRIC = 1'b0;
  localparam logic CFG_SIZE      = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] c;
    logic [VAL_W-1:0] v;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic acc_clr;
    logic ent_rd;
    logic vec_rd;
    logic mul_fwd;
    logic acc_fwd;
    logic mul_mir;
    logic acc_mir;
    logic out_rd;
    logic out_emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_last;
    logic ent_done;
    logic in_range;
    logic mirror;
  } sts_t;

endpackage

// ===== hdl/smv_ctrl.sv =====
// Run sequencer of the sparse matrix vector block.
module smv_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         run_go,
  input  smv_pkg::sts_t sts,
  output smv_pkg::cmd_t cmd,
  output logic         busy
);
  import smv_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CLR  = 10'b0000000010,
    S_ECHK = 10'b0000000100,
    S_VEC  = 10'b0000001000,
    S_MULF = 10'b0000010000,
    S_ACCF = 10'b0000100000,
    S_MULM = 10'b0001000000,
    S_ACCM = 10'b0010000000,
    S_ORD  = 10'b0100000000,
    S_OEM  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (run_go) begin
          cmd.init  = 1'b1;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.acc_clr = 1'b1;
        if (sts.row_last) begin
          cmd.init  = 1'b1;
          state_nxt = S_ECHK;
        end
      end
      S_ECHK: begin
        if (sts.ent_done) begin
          state_nxt = S_ORD;
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_VEC;
        end
      end
      S_VEC: begin
        if (sts.in_range) begin
          cmd.vec_rd = 1'b1;
          state_nxt  = S_MULF;
        end else begin
          state_nxt = S_ECHK;
        end
      end
      S_MULF: begin
        cmd.mul_fwd = 1'b1;
        state_nxt   = S_ACCF;
      end
      S_ACCF: begin
        cmd.acc_fwd = 1'b1;
        state_nxt   = sts.mirror ? S_MULM : S_ECHK;
      end
      S_MULM: begin
        cmd.mul_mir = 1'b1;
        state_nxt   = S_ACCM;
      end
      S_ACCM: begin
        cmd.acc_mir = 1'b1;
        state_nxt   = S_ECHK;
      end
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OEM;
      end
      S_OEM: begin
        cmd.out_emit = 1'b1;
        state_nxt    = sts.row_last ? S_IDLE : S_ORD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/smv_dp.sv =====
// Stores, multiplier and accumulators of the sparse matrix vector block.
module smv_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load_en,
  input  logic [1:0]                  in_req_type,
  input  logic [smv_pkg::ROW_W-1:0]   in_row,
  input  logic [smv_pkg::ROW_W-1:0]   in_col,
  input  logic signed [smv_pkg::VAL_W-1:0] in_value,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [6:0]                  cfg_data,
  input  smv_pkg::cmd_t               cmd,
  output smv_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [smv_pkg::ROW_W-1:0]   out_row_index,
  output logic signed [smv_pkg::VAL_W-1:0] out_result_value,
  output logic                        out_last,
  output logic                        out_store_overflowed
);
  import smv_pkg::*;

  entry_t             ent_mem [NNZ_MAX];
  logic [VAL_W-1:0]   vec_mem [DIM];
  logic [ACC_W-1:0]   acc_mem [DIM];

  logic               sym_r;
  logic [6:0]         size_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   idx_r;
  logic [N_W-1:0]     row_r;
  entry_t             ent_q;
  logic [VAL_W-1:0]   vc_q, vr_q;
  logic [ACC_W-1:0]   acc_q;
  logic signed [63:0] prod_r;
  logic [N_W-1:0]     n;
  logic [VIDX_W-1:0]  acc_raddr;
  logic [ACC_W-1:0]   acc_sum;
  logic [VAL_W-1:0]   sat_val;

  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_last_r;
  logic               out_ovf_r;

  // Effective dimension of a run.
  always_comb begin
    if (size_r == 7'd0) begin
      n = N_W'(1);
    end else if (size_r > 7'(DIM)) begin
      n = N_W'(DIM);
    end else begin
      n = N_W'(size_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r  <= 1'b0;
      size_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYMMETRIC) begin
        sym_r <= cfg_data[0];
      end else begin
        size_r <= cfg_data;
      end
    end
  end

  // Entry count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (load_en) begin
      if (in_req_type == REQ_CLEAR) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (in_req_type == REQ_LOAD_ENTRY) begin
        if (cnt_r == CNT_W'(NNZ_MAX)) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Entry store: written at the fill count, read at the run index.
  always_ff @(posedge clk) begin
    if (load_en && (in_req_type == REQ_LOAD_ENTRY) && (cnt_r != CNT_W'(NNZ_MAX))) begin
      ent_mem[cnt_r[IDX_W-1:0]] <= '{r: in_row, c: in_col, v: in_value};
    end
    if (cmd.ent_rd) begin
      ent_q <= ent_mem[idx_r[IDX_W-1:0]];
    end
  end

  // Vector store with two read ports.
  always_ff @(posedge clk) begin
    if (load_en && (in_req_type == REQ_LOAD_VEC) && (7'(in_row) < 7'(DIM))) begin
      vec_mem[in_row[VIDX_W-1:0]] <= in_value;
    end
    if (cmd.vec_rd) begin
      vc_q <= vec_mem[ent_q.c[VIDX_W-1:0]];
      vr_q <= vec_mem[ent_q.r[VIDX_W-1:0]];
    end
  end

  // Multiplier, one product per command.
  always_ff @(posedge clk) begin
    if (cmd.mul_fwd) begin
      prod_r <= $signed(ent_q.v) * $signed(vc_q);
    end else if (cmd.mul_mir) begin
      prod_r <= $signed(ent_q.v) * $signed(vr_q);
    end
  end

  // Accumulator read address.
  always_comb begin
    if (cmd.mul_fwd) begin
      acc_raddr = ent_q.r[VIDX_W-1:0];
    end else if (cmd.mul_mir) begin
      acc_raddr = ent_q.c[VIDX_W-1:0];
    end else begin
      acc_raddr = row_r[VIDX_W-1:0];
    end
  end

  // Truncated product added to the accumulator, modulo 2^48.
  assign acc_sum = acc_q + prod_r[63:16];

  // Accumulator memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.mul_fwd || cmd.mul_mir || cmd.out_rd) begin
      acc_q <= acc_mem[acc_raddr];
    end
    if (cmd.acc_clr) begin
      acc_mem[row_r[VIDX_W-1:0]] <= '0;
    end else if (cmd.acc_fwd) begin
      acc_mem[ent_q.r[VIDX_W-1:0]] <= acc_sum;
    end else if (cmd.acc_mir) begin
      acc_mem[ent_q.c[VIDX_W-1:0]] <= acc_sum;
    end
  end

  // Entry index and row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      row_r <= '0;
    end else begin
      if (cmd.init) begin
        idx_r <= '0;
        row_r <= '0;
      end else begin
        if (cmd.ent_rd) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (cmd.acc_clr || cmd.out_emit) begin
          row_r <= row_r + N_W'(1);
        end
      end
    end
  end

  // Saturate the 48-bit sum to 32 bits.
  always_comb begin
    if ((&acc_q[ACC_W-1:VAL_W-1]) || !(|acc_q[ACC_W-1:VAL_W-1])) begin
      sat_val = acc_q[VAL_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_emit;
    end
    if (cmd.out_emit) begin
      out_row_r  <= ROW_W'(row_r);
      out_val_r  <= sat_val;
      out_last_r <= sts.row_last;
      out_ovf_r  <= ovf_r;
    end
  end

  // Status to the controller.
  assign sts.row_last = (row_r == (n - N_W'(1)));
  assign sts.ent_done = (idx_r == cnt_r);
  assign sts.in_range = (7'(ent_q.r) < 7'(n)) && (7'(ent_q.c) < 7'(n));
  assign sts.mirror   = sym_r && (ent_q.r != ent_q.c);

  assign out_valid            = out_valid_r;
  assign out_row_index        = out_row_r;
  assign out_result_value     = out_val_r;
  assign out_last             = out_last_r;
  assign out_store_overflowed = out_ovf_r;

endmodule

// ===== hdl/sparse_matrix_vector_multiply.sv =====
// Top level of the sparse matrix vector multiply block.
// Usage: a request word is taken when start is high and busy is low.
// Matrix entry loads, vector loads and clears take effect in the cycle
// they are taken and give no result, so they may follow each other every
// cycle. A run request raises busy. The run first zeroes n accumulators,
// then walks every stored entry: a fetch state and a range-check state,
// then a multiply state and an accumulate state for an entry inside the
// size, and another multiply and accumulate pair when a symmetric entry
// adds its mirrored term. Then it emits rows 0..n-1, reading each row's
// accumulator and then emitting its result word on out_valid, the last
// one flagged by out_last. Entries outside the size are skipped after the
// range check. Each accumulator update is a read followed by a write. The
// receiver cannot stall: each result word shows for one cycle only.
// Configuration writes are always ready and must be made while busy is
// low. Reset empties the entry store, clears the overflow flag and sets
// symmetric mode off and size 64.
module sparse_matrix_vector_multiply (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic [smv_pkg::ROW_W-1:0]        in_row,
  input  logic [smv_pkg::ROW_W-1:0]        in_col,
  input  logic signed [smv_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic [smv_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [smv_pkg::VAL_W-1:0] out_result_value,
  output logic                             out_last,
  output logic                             out_store_overflowed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [6:0]                       cfg_data
);
  import smv_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic load_en;
  logic run_go;

  // Accepted request word.
  assign load_en   = start && !busy;
  assign run_go    = load_en && (in_req_type == REQ_RUN);
  assign cfg_ready = 1'b1;

  smv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .run_go (run_go),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  smv_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load_en              (load_en),
    .in_req_type          (in_req_type),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_value             (in_value),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_row_index        (out_row_index),
    .out_result_value     (out_result_value),
    .out_last             (out_last),
    .out_store_overflowed (out_store_overflowed)
  );

endmodule

// ===== hdl/smv_checker.sv =====
// Port-level checker of the sparse matrix vector block and its bind.
`include "sparse_matrix_vector_multiply_defines.svh"

module smv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_last
);
  import smv_pkg::*;

  // A result word only comes out of a run.
  `SMV_ASSERT_IMP(a_out_in_run, out_valid, $past(busy))
  // Result words never come in adjacent cycles.
  `SMV_ASSERT_NXT(a_out_spaced, out_valid, !out_valid)
  // A word that is not the last leaves the run still going.
  `SMV_ASSERT_IMP(a_more_rows, out_valid && !out_last, busy)
  // An accepted run request starts a run.
  `SMV_ASSERT_NXT(a_run_starts, start && !busy && (in_req_type == REQ_RUN), busy)

endmodule

bind sparse_matrix_vector_multiply smv_checker u_smv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_last    (out_last)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the sparse matrix vector multiply block.
`timescale 1ns / 100ps

module testbench;
  import smv_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  // One expected row of a run.
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] val;
    logic             last;
    logic             ovf;
  } row_word_t;

  // Keeps a private copy of the block's stores and predicts every run.
  class spmv_scoreboard;
    entry_t           entries[$];
    logic [VAL_W-1:0] vec[DIM];
    bit               ovf_flag;
    bit               sym_mode;
    logic [6:0]       size_reg;
    row_word_t        rows_due[$];
    int               errors;

    function new();
      ovf_flag = 0;
      sym_mode = 0;
      size_reg = 7'd64;
      errors = 0;
      foreach (vec[i]) vec[i] = '0;
    endfunction

    function void note_cfg(logic idx, logic [6:0] data);
      if (idx == CFG_SYMMETRIC) sym_mode = data[0];
      else size_reg = data;
    endfunction

    // Q16.16 product truncated toward minus infinity, as a 48-bit pattern.
    function logic [ACC_W-1:0] q16_product(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic signed [63:0] p;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      p = sa * sb;
      return p[63:16];
    endfunction

    function logic [VAL_W-1:0] saturate(logic [ACC_W-1:0] acc);
      longint x;
      x = $signed(acc);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      return x[31:0];
    endfunction

    function void note_input(logic [1:0] req, logic [5:0] r, logic [5:0] c,
                             logic [VAL_W-1:0] v);
      logic [ACC_W-1:0] acc[DIM];
      row_word_t w;
      int n;
      case (req)
        REQ_LOAD_ENTRY: begin
          if (entries.size() >= NNZ_MAX) ovf_flag = 1;
          else entries.push_back('{r: r, c: c, v: v});
        end
        REQ_LOAD_VEC: vec[r] = v;
        REQ_CLEAR: begin
          entries.delete();
          ovf_flag = 0;
        end
        default: begin
          n = (size_reg == 0) ? 1 : (size_reg > DIM) ? DIM : size_reg;
          foreach (acc[i]) acc[i] = '0;
          foreach (entries[i]) begin
            if (entries[i].r < n && entries[i].c < n) begin
              acc[entries[i].r] += q16_product(entries[i].v, vec[entries[i].c]);
              if (sym_mode && entries[i].r != entries[i].c)
                acc[entries[i].c] += q16_product(entries[i].v, vec[entries[i].r]);
            end
          end
          for (int i = 0; i < n; i++) begin
            w.row = ROW_W'(i);
            w.val = saturate(acc[i]);
            w.last = (i == n - 1);
            w.ovf = ovf_flag;
            rows_due.push_back(w);
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [ROW_W-1:0] row, logic [VAL_W-1:0] val, logic last,
                      logic ovf);
      row_word_t w;
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected result word row %0d", row));
      end else begin
        w = rows_due.pop_front();
        if (row !== w.row) report($sformatf("row_index %0d, want %0d", row, w.row));
        if (val !== w.val)
          report($sformatf("row %0d value %h, want %h", w.row, val, w.val));
        if (last !== w.last) report($sformatf("row %0d last %b, want %b", w.row, last, w.last));
        if (ovf !== w.ovf)
          report($sformatf("row %0d overflowed %b, want %b", w.row, ovf, w.ovf));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_req_type;
  logic [ROW_W-1:0]        in_row;
  logic [ROW_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_row_index;
  logic signed [VAL_W-1:0] out_result_value;
  logic                    out_last;
  logic                    out_store_overflowed;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic                    cfg_index;
  logic [6:0]              cfg_data;

  spmv_scoreboard board = new();
  bit idle_on;
  int cycles = 0;

  sparse_matrix_vector_multiply uut (.*);

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch accepted request words, configuration writes and result words.
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_input(in_req_type, in_row, in_col, in_value);
    if (rst_n && cfg_valid && cfg_ready) board.note_cfg(cfg_index, cfg_data);
    if (rst_n && out_valid)
      board.check_result(out_row_index, out_result_value, out_last, out_store_overflowed);
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Sends one request word, at times with a random idle burst ahead of it.
  task send_word(logic [1:0] req, logic [5:0] r, logic [5:0] c, logic [VAL_W-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Waits for every expected row and a little settling time.
  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (board.rows_due.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_cfg(logic idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Values biased toward the extremes so saturation and wrap occur.
  function logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'd127;
      3: return $urandom_range(1, 127);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int n;
    int cnt;
    logic [6:0] sz;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_LOAD_ENTRY;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SYMMETRIC;
    cfg_data = '0;
    idle_on = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(CFG_SYMMETRIC, 7'd0);
    write_cfg(CFG_SIZE, 7'd64);

    // Every vector element is written before the first run.
    for (int i = 0; i < DIM; i++) send_word(REQ_LOAD_VEC, i, $urandom, pick_value());
    send_word(REQ_LOAD_VEC, 0, 6'd63, 32'h7FFFFFFF);
    send_word(REQ_LOAD_VEC, 1, 6'd0, 32'h80000000);
    send_word(REQ_LOAD_VEC, 63, 6'd21, 32'h00010000);

    // Directed: extremes, duplicates, an upper entry and an empty store.
    send_word(REQ_RUN, 0, 0, 0);
    send_word(REQ_LOAD_ENTRY, 0, 0, 32'h7FFFFFFF);
    send_word(REQ_LOAD_ENTRY, 0, 1, 32'h80000000);
    send_word(REQ_LOAD_ENTRY, 63, 63, 32'h7FFFFFFF);
    send_word(REQ_LOAD_ENTRY, 5, 3, 32'hFFFFFFFF);
    send_word(REQ_LOAD_ENTRY, 5, 3, 32'hFFFFFFFF);
    send_word(REQ_LOAD_ENTRY, 3, 5, 32'h00018000);
    send_word(REQ_LOAD_ENTRY, 63, 0, 32'h80000000);
    send_word(REQ_LOAD_ENTRY, 1, 1, 32'h80000000);
    send_word(REQ_RUN, 0, 0, 0);
    wait_idle();
    write_cfg(CFG_SYMMETRIC, 7'h7F);
    send_word(REQ_RUN, 0, 0, 0);
    wait_idle();
    write_cfg(CFG_SIZE, 7'd0);
    send_word(REQ_RUN, 0, 0, 0);
    wait_idle();
    write_cfg(CFG_SIZE, 7'd127);
    send_word(REQ_RUN, 0, 0, 0);
    send_word(REQ_CLEAR, 6'h3F, 6'h3F, 32'hFFFFFFFF);
    send_word(REQ_RUN, 0, 0, 0);
    wait_idle();

    // Random phases: both settings, an optional clear, a few loads, then a run.
    for (int ph = 0; ph < 14; ph++) begin
      idle_on = (ph < 11);
      write_cfg(CFG_SYMMETRIC, $urandom);
      sz = pick_size();
      write_cfg(CFG_SIZE, sz);
      n = (sz == 0) ? 1 : (sz > DIM) ? DIM : sz;
      if ($urandom_range(0, 2) != 0) send_word(REQ_CLEAR, $urandom, $urandom, $urandom);
      cnt = $urandom_range(6, 22);
      for (int k = 0; k < cnt; k++) begin
        case ($urandom_range(0, 9))
          0: send_word(REQ_LOAD_VEC, $urandom, $urandom, pick_value());
          1: send_word(REQ_LOAD_ENTRY, $urandom, $urandom, pick_value());
          2: if ($urandom_range(0, 3) == 0) send_word(REQ_RUN, 0, 0, 0);
          default: send_word(REQ_LOAD_ENTRY, $urandom_range(0, n - 1),
                             $urandom_range(0, n - 1), pick_value());
        endcase
      end
      send_word(REQ_RUN, $urandom, $urandom, $urandom);
      wait_idle();
    end

    // Closing words without idling: a clear, one entry and a run.
    idle_on = 0;
    write_cfg(CFG_SIZE, 7'd8);
    send_word(REQ_CLEAR, 0, 0, 0);
    send_word(REQ_LOAD_ENTRY, 2, 7, pick_value());
    send_word(REQ_RUN, 0, 0, 0);
    wait_idle();

    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
